// File: rtl/rvex_pkg.sv
// ----------------------------------------------------------------------------
// rvex_pkg
// Shared codes, operation selects and stage payload types for the RV32I
// integer execute pipeline.
// ----------------------------------------------------------------------------
package rvex_pkg;

  localparam int XLEN = 32;

  // Operation class codes
  localparam logic [2:0] MODE_UPPER  = 3'd0;
  localparam logic [2:0] MODE_JAL    = 3'd1;
  localparam logic [2:0] MODE_JALR   = 3'd2;
  localparam logic [2:0] MODE_OPIMM  = 3'd3;
  localparam logic [2:0] MODE_BRANCH = 3'd4;
  localparam logic [2:0] MODE_OP     = 3'd5;

  // ALU funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Branch funct3 codes
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // Link address step and jalr target mask
  localparam logic [XLEN-1:0] PC_STEP   = 32'd4;
  localparam logic [XLEN-1:0] JALR_MASK = 32'hFFFF_FFFE;
  localparam int              SHAMT_W   = 5;

  typedef enum logic [3:0] {
    ALU_ZERO,
    ALU_ADD,
    ALU_SUB,
    ALU_SLL,
    ALU_SLT,
    ALU_SLTU,
    ALU_XOR,
    ALU_SRL,
    ALU_SRA,
    ALU_OR,
    ALU_AND,
    ALU_PASS,
    ALU_LINK
  } alu_op_t;

  typedef enum logic [2:0] {
    BR_NONE,
    BR_ALWAYS,
    BR_EQ,
    BR_NE,
    BR_LT,
    BR_GE,
    BR_LTU,
    BR_GEU
  } br_cond_t;

  // Decode stage to ALU stage
  typedef struct packed {
    alu_op_t         alu_op;
    br_cond_t        br;
    logic            jalr;
    logic            wr;
    logic            bad;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] imm;
    logic [XLEN-1:0] pc;
    logic [4:0]      rd;
  } dec_t;

  // ALU stage to resolve stage
  typedef struct packed {
    logic [XLEN-1:0] value;
    logic            wr;
    logic            bad;
    logic            taken;
    logic            jalr;
    logic [XLEN-1:0] base;
    logic [XLEN-1:0] imm;
    logic [XLEN-1:0] pc;
    logic [4:0]      rd;
  } ex_t;

endpackage

// File: rtl/rvex_if.sv
// ----------------------------------------------------------------------------
// rvex_in_if / rvex_out_if
// Valid/ready channels carrying one instruction word in and one result word
// out of the execute pipeline.
// ----------------------------------------------------------------------------
interface rvex_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [2:0]         funct3;
  logic               alt_bit;
  logic [31:0]        rs1_value;
  logic [31:0]        rs2_value;
  logic signed [31:0] imm;
  logic [31:0]        pc;
  logic [4:0]         rd_index;

  modport source (output valid, mode, funct3, alt_bit, rs1_value, rs2_value, imm, pc,
                  rd_index, input ready);
  modport sink (input valid, mode, funct3, alt_bit, rs1_value, rs2_value, imm, pc,
                rd_index, output ready);
endinterface

interface rvex_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rd_value;
  logic        rd_write;
  logic [4:0]  rd_out;
  logic [31:0] next_pc;
  logic        taken;
  logic        unsupported;

  modport source (output valid, rd_value, rd_write, rd_out, next_pc, taken, unsupported,
                  input ready);
  modport sink (input valid, rd_value, rd_write, rd_out, next_pc, taken, unsupported,
                output ready);
endinterface

// File: rtl/rvex_decode.sv
// ----------------------------------------------------------------------------
// rvex_decode
// First pipeline stage: decode class and funct3 into ALU and branch selects,
// pick the second operand and register the word.
// ----------------------------------------------------------------------------
module rvex_decode (
  input  logic              clk,
  input  logic              rst,
  rvex_in_if.sink           instr,
  output logic              valid,
  input  logic              ready,
  output rvex_pkg::dec_t    dec
);

  rvex_pkg::dec_t dec_next;
  logic           advance;
  logic [31:0]    imm12;

  // Stage moves when empty or when the next stage takes its word
  assign advance     = !valid || ready;
  assign instr.ready = advance;

  // Sign-extend the low 12 bits of the immediate
  assign imm12 = {{20{instr.imm[11]}}, instr.imm[11:0]};

  // Decode class and funct3
  always_comb begin
    dec_next        = '0;
    dec_next.alu_op = rvex_pkg::ALU_ZERO;
    dec_next.br     = rvex_pkg::BR_NONE;
    dec_next.a      = instr.rs1_value;
    dec_next.b      = instr.rs2_value;
    dec_next.imm    = $unsigned(instr.imm);
    dec_next.pc     = instr.pc;
    dec_next.rd     = instr.rd_index;
    unique case (instr.mode)
      rvex_pkg::MODE_UPPER: begin
        dec_next.alu_op = rvex_pkg::ALU_PASS;
        dec_next.wr     = 1'b1;
      end
      rvex_pkg::MODE_JAL: begin
        dec_next.alu_op = rvex_pkg::ALU_LINK;
        dec_next.br     = rvex_pkg::BR_ALWAYS;
        dec_next.wr     = 1'b1;
      end
      rvex_pkg::MODE_JALR: begin
        dec_next.alu_op = rvex_pkg::ALU_LINK;
        dec_next.br     = rvex_pkg::BR_ALWAYS;
        dec_next.jalr   = 1'b1;
        dec_next.wr     = 1'b1;
      end
      rvex_pkg::MODE_OPIMM: begin
        dec_next.b  = imm12;
        dec_next.wr = 1'b1;
        unique case (instr.funct3) inside
          rvex_pkg::F3_ADD:  dec_next.alu_op = rvex_pkg::ALU_ADD;
          rvex_pkg::F3_SLT:  dec_next.alu_op = rvex_pkg::ALU_SLT;
          rvex_pkg::F3_SLTU: dec_next.alu_op = rvex_pkg::ALU_SLTU;
          rvex_pkg::F3_XOR:  dec_next.alu_op = rvex_pkg::ALU_XOR;
          rvex_pkg::F3_OR:   dec_next.alu_op = rvex_pkg::ALU_OR;
          rvex_pkg::F3_AND:  dec_next.alu_op = rvex_pkg::ALU_AND;
          rvex_pkg::F3_SLL, rvex_pkg::F3_SR: begin
            dec_next.wr  = 1'b0;
            dec_next.bad = 1'b1;
          end
          default: dec_next.bad = 1'b1;
        endcase
      end
      rvex_pkg::MODE_BRANCH: begin
        unique case (instr.funct3) inside
          rvex_pkg::F3_BEQ:  dec_next.br = rvex_pkg::BR_EQ;
          rvex_pkg::F3_BNE:  dec_next.br = rvex_pkg::BR_NE;
          rvex_pkg::F3_BLT:  dec_next.br = rvex_pkg::BR_LT;
          rvex_pkg::F3_BGE:  dec_next.br = rvex_pkg::BR_GE;
          rvex_pkg::F3_BLTU: dec_next.br = rvex_pkg::BR_LTU;
          rvex_pkg::F3_BGEU: dec_next.br = rvex_pkg::BR_GEU;
          default:           dec_next.bad = 1'b1;
        endcase
      end
      rvex_pkg::MODE_OP: begin
        dec_next.wr = 1'b1;
        unique case (instr.funct3)
          rvex_pkg::F3_ADD: dec_next.alu_op = instr.alt_bit ? rvex_pkg::ALU_SUB
                                                            : rvex_pkg::ALU_ADD;
          rvex_pkg::F3_SLL:  dec_next.alu_op = rvex_pkg::ALU_SLL;
          rvex_pkg::F3_SLT:  dec_next.alu_op = rvex_pkg::ALU_SLT;
          rvex_pkg::F3_SLTU: dec_next.alu_op = rvex_pkg::ALU_SLTU;
          rvex_pkg::F3_XOR:  dec_next.alu_op = rvex_pkg::ALU_XOR;
          rvex_pkg::F3_SR:  dec_next.alu_op = instr.alt_bit ? rvex_pkg::ALU_SRA
                                                            : rvex_pkg::ALU_SRL;
          rvex_pkg::F3_OR:   dec_next.alu_op = rvex_pkg::ALU_OR;
          default:           dec_next.alu_op = rvex_pkg::ALU_AND;
        endcase
      end
      default: dec_next.bad = 1'b1;
    endcase
  end

  // Hold or advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && instr.valid) begin
      dec <= dec_next;
    end
  end

endmodule

// File: rtl/rvex_alu.sv
// ----------------------------------------------------------------------------
// rvex_alu
// Second pipeline stage: integer ALU, link address and branch condition.
// ----------------------------------------------------------------------------
module rvex_alu (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  rvex_pkg::dec_t dec,
  output logic           valid,
  input  logic           ready,
  output rvex_pkg::ex_t  ex
);

  rvex_pkg::ex_t                  ex_next;
  logic [rvex_pkg::SHAMT_W-1:0]   sh;
  logic                           eq;
  logic                           lt;
  logic                           ltu;
  logic                           cond;

  assign up_ready = !valid || ready;

  // Compare operands
  assign sh  = dec.b[rvex_pkg::SHAMT_W-1:0];
  assign eq  = (dec.a == dec.b);
  assign lt  = ($signed(dec.a) < $signed(dec.b));
  assign ltu = (dec.a < dec.b);

  // Evaluate branch condition
  always_comb begin
    case (dec.br)
      rvex_pkg::BR_ALWAYS: cond = 1'b1;
      rvex_pkg::BR_EQ:     cond = eq;
      rvex_pkg::BR_NE:     cond = !eq;
      rvex_pkg::BR_LT:     cond = lt;
      rvex_pkg::BR_GE:     cond = !lt;
      rvex_pkg::BR_LTU:    cond = ltu;
      rvex_pkg::BR_GEU:    cond = !ltu;
      default:             cond = 1'b0;
    endcase
  end

  // Compute the write value
  always_comb begin
    ex_next       = '0;
    ex_next.wr    = dec.wr;
    ex_next.bad   = dec.bad;
    ex_next.taken = cond;
    ex_next.jalr  = dec.jalr;
    ex_next.base  = dec.a;
    ex_next.imm   = dec.imm;
    ex_next.pc    = dec.pc;
    ex_next.rd    = dec.rd;
    unique case (dec.alu_op)
      rvex_pkg::ALU_ADD:  ex_next.value = dec.a + dec.b;
      rvex_pkg::ALU_SUB:  ex_next.value = dec.a - dec.b;
      rvex_pkg::ALU_SLL:  ex_next.value = dec.a << sh;
      rvex_pkg::ALU_SLT:  ex_next.value = {31'd0, lt};
      rvex_pkg::ALU_SLTU: ex_next.value = {31'd0, ltu};
      rvex_pkg::ALU_XOR:  ex_next.value = dec.a ^ dec.b;
      rvex_pkg::ALU_SRL:  ex_next.value = dec.a >> sh;
      rvex_pkg::ALU_SRA:  ex_next.value = $unsigned($signed(dec.a) >>> sh);
      rvex_pkg::ALU_OR:   ex_next.value = dec.a | dec.b;
      rvex_pkg::ALU_AND:  ex_next.value = dec.a & dec.b;
      rvex_pkg::ALU_PASS: ex_next.value = dec.imm;
      rvex_pkg::ALU_LINK: ex_next.value = dec.pc + rvex_pkg::PC_STEP;
      default:            ex_next.value = '0;
    endcase
  end

  // Hold or advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ex <= ex_next;
    end
  end

endmodule

// File: rtl/rvex_resolve.sv
// ----------------------------------------------------------------------------
// rvex_resolve
// Third pipeline stage: form the jump or branch target, pick the next pc and
// drive the result word register.
// ----------------------------------------------------------------------------
module rvex_resolve (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  rvex_pkg::ex_t ex,
  rvex_out_if.source    result
);

  logic [31:0] sum;
  logic [31:0] target;
  logic [31:0] seq;

  assign up_ready = !result.valid || result.ready;

  // Form target and fall-through address
  assign sum    = (ex.jalr ? ex.base : ex.pc) + ex.imm;
  assign target = ex.jalr ? (sum & rvex_pkg::JALR_MASK) : sum;
  assign seq    = ex.pc + rvex_pkg::PC_STEP;

  // Hold or advance the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (up_ready) begin
      result.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      result.rd_value    <= ex.value;
      result.rd_write    <= ex.wr;
      result.rd_out      <= ex.rd;
      result.next_pc     <= ex.taken ? target : seq;
      result.taken       <= ex.taken;
      result.unsupported <= ex.bad;
    end
  end

endmodule

// File: rtl/rv32i_integer_execute_core.sv
// ----------------------------------------------------------------------------
// rv32i_integer_execute_core
// RV32I execute stage: ALU ops, upper-immediate write, jal, jalr and
// conditional branches, as a three-stage valid/ready pipeline.
// ----------------------------------------------------------------------------
//   channel  | dir | word contents
//   ---------+-----+-----------------------------------------------------------
//   instr    | in  | mode, funct3, alt_bit, rs1_value, rs2_value, imm, pc,
//            |     | rd_index
//   result   | out | rd_value, rd_write, rd_out, next_pc, taken, unsupported
//
// Three register stages (decode, ALU, resolve): an accepted word passes through
// the decode, ALU and resolve registers in order, and result valid rises with the last.
// One instruction word is accepted every cycle while result.ready is high.
// Each stage advances when empty or when the stage after it moves, so a stall
// backs up stage by stage and fills bubbles without dropping a word.
// Synchronous reset clears all stage valid bits; payload is not reset.
module rv32i_integer_execute_core (
  input logic       clk,
  input logic       rst,
  rvex_in_if.sink   instr,
  rvex_out_if.source result
);

  logic           dec_valid;
  logic           dec_ready;
  rvex_pkg::dec_t dec;
  logic           ex_valid;
  logic           ex_ready;
  rvex_pkg::ex_t  ex;

  // Decode stage
  rvex_decode u_decode (
    .clk   (clk),
    .rst   (rst),
    .instr (instr),
    .valid (dec_valid),
    .ready (dec_ready),
    .dec   (dec)
  );

  // ALU stage
  rvex_alu u_alu (
    .clk      (clk),
    .rst      (rst),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .dec      (dec),
    .valid    (ex_valid),
    .ready    (ex_ready),
    .ex       (ex)
  );

  // Resolve stage and output register
  rvex_resolve u_resolve (
    .clk      (clk),
    .rst      (rst),
    .up_valid (ex_valid),
    .up_ready (ex_ready),
    .ex       (ex),
    .result   (result)
  );

endmodule

// File: rtl/rvex_checker.sv
// ----------------------------------------------------------------------------
// rvex_checker
// Port-level checks on the execute pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rvex_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] rd_value,
  input logic        rd_write,
  input logic [31:0] next_pc,
  input logic        taken,
  input logic        unsupported
);

  // Reset empties the pipeline
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A free output side never blocks the input side
  assert property (@(posedge clk) disable iff (rst) out_ready |-> in_ready)
    else $error("input stalled while output is free");

  // Unsupported words neither write nor redirect
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && unsupported) |-> (!rd_write && !taken))
    else $error("unsupported word writes or redirects");

  // A word without a write carries a zero value
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rd_write) |-> (rd_value == 32'd0))
    else $error("nonzero value on a word without write");

  // A stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(rd_value) && $stable(next_pc) && $stable(taken)))
    else $error("stalled result word changed");

endmodule

bind rv32i_integer_execute_core rvex_checker u_rvex_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (instr.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .rd_value    (result.rd_value),
  .rd_write    (result.rd_write),
  .next_pc     (result.next_pc),
  .taken       (result.taken),
  .unsupported (result.unsupported)
);

// File: dv/rv32i_integer_execute_core_checker.sv
// ----------------------------------------------------------------------------
// rv32i_integer_execute_core_checker
// Watches the instruction and result channels of the execute core. Predicts
// each result from the accepted instruction word, queues it, and compares the
// queue head field by field against every accepted result word.
// ----------------------------------------------------------------------------
module rv32i_integer_execute_core_checker
  import rvex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rvex_in_if          instr,
  rvex_out_if         result,
  output int unsigned error_count,
  output int unsigned pending_count,
  output int unsigned checked_count,
  output int unsigned taken_count,
  output int unsigned unsupported_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [31:0] rd_value;
    logic        rd_write;
    logic [4:0]  rd_out;
    logic [31:0] next_pc;
    logic        taken;
    logic        unsupported;
  } exec_result_t;

  exec_result_t expected_results[$];
  int unsigned  errors;
  int unsigned  checked;
  int unsigned  redirects;
  int unsigned  rejects;

  // Compute the result word one instruction word produces
  function automatic exec_result_t execute_word(
    input logic [2:0]  mode,
    input logic [2:0]  f3,
    input logic        alt,
    input logic [31:0] a,
    input logic [31:0] b,
    input logic [31:0] imm,
    input logic [31:0] pc,
    input logic [4:0]  rd
  );
    exec_result_t r;
    logic [31:0]  link;
    logic [31:0]  simm;
    logic [4:0]   shamt;
    logic         cond;
    link      = pc + PC_STEP;
    simm      = {{20{imm[11]}}, imm[11:0]};
    shamt     = b[SHAMT_W-1:0];
    cond      = 1'b0;
    r         = '0;
    r.rd_out  = rd;
    r.next_pc = link;
    case (mode)
      MODE_UPPER: begin
        r.rd_value = imm;
        r.rd_write = 1'b1;
      end
      MODE_JAL: begin
        r.next_pc  = pc + imm;
        r.taken    = 1'b1;
        r.rd_value = link;
        r.rd_write = 1'b1;
      end
      MODE_JALR: begin
        r.next_pc  = (a + imm) & JALR_MASK;
        r.taken    = 1'b1;
        r.rd_value = link;
        r.rd_write = 1'b1;
      end
      MODE_OPIMM: begin
        r.rd_write = 1'b1;
        case (f3)
          F3_ADD:  r.rd_value = a + simm;
          F3_SLT:  r.rd_value = {31'b0, $signed(a) < $signed(simm)};
          F3_SLTU: r.rd_value = {31'b0, a < simm};
          F3_XOR:  r.rd_value = a ^ simm;
          F3_OR:   r.rd_value = a | simm;
          F3_AND:  r.rd_value = a & simm;
          default: begin
            // shift-immediates are not handled here
            r.rd_write    = 1'b0;
            r.unsupported = 1'b1;
          end
        endcase
      end
      MODE_BRANCH: begin
        case (f3)
          F3_BEQ:  cond = (a == b);
          F3_BNE:  cond = (a != b);
          F3_BLT:  cond = ($signed(a) < $signed(b));
          F3_BGE:  cond = ($signed(a) >= $signed(b));
          F3_BLTU: cond = (a < b);
          F3_BGEU: cond = (a >= b);
          default: r.unsupported = 1'b1;
        endcase
        if (cond) begin
          r.taken   = 1'b1;
          r.next_pc = pc + imm;
        end
      end
      MODE_OP: begin
        r.rd_write = 1'b1;
        case (f3)
          F3_ADD: begin
            if (alt) r.rd_value = a - b;
            else     r.rd_value = a + b;
          end
          F3_SLL:  r.rd_value = a << shamt;
          F3_SLT:  r.rd_value = {31'b0, $signed(a) < $signed(b)};
          F3_SLTU: r.rd_value = {31'b0, a < b};
          F3_XOR:  r.rd_value = a ^ b;
          F3_SR: begin
            // keep the signed shift in its own statement so it stays arithmetic
            if (alt) r.rd_value = $signed(a) >>> shamt;
            else     r.rd_value = a >> shamt;
          end
          F3_OR:   r.rd_value = a | b;
          default: r.rd_value = a & b;
        endcase
      end
      default: r.unsupported = 1'b1;
    endcase
    return r;
  endfunction

  initial begin
    errors    = 0;
    checked   = 0;
    redirects = 0;
    rejects   = 0;
  end

  // Queue predictions on instruction accept, retire them on result accept
  always @(posedge clk) begin
    exec_result_t want;
    exec_result_t got;
    logic         bad;
    if (!rst) begin
      if (instr.valid && instr.ready) begin
        expected_results.push_back(execute_word(instr.mode, instr.funct3, instr.alt_bit,
                                                instr.rs1_value, instr.rs2_value,
                                                instr.imm, instr.pc, instr.rd_index));
      end
      if (result.valid && result.ready) begin
        got.rd_value    = result.rd_value;
        got.rd_write    = result.rd_write;
        got.rd_out      = result.rd_out;
        got.next_pc     = result.next_pc;
        got.taken       = result.taken;
        got.unsupported = result.unsupported;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $display("[%0t] result word with nothing expected: val=%h wr=%b rd=%0d npc=%h",
                     $time, got.rd_value, got.rd_write, got.rd_out, got.next_pc);
          end
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (want.taken)       redirects++;
          if (want.unsupported) rejects++;
          bad = (got.rd_value !== want.rd_value) || (got.rd_write !== want.rd_write) ||
                (got.rd_out !== want.rd_out) || (got.next_pc !== want.next_pc) ||
                (got.taken !== want.taken) || (got.unsupported !== want.unsupported);
          if (bad) begin
            errors++;
            if (errors <= REPORT_MAX) begin
              $display("[%0t] result %0d mismatch", $time, checked);
              $display("  expected: val=%h wr=%b rd=%0d npc=%h taken=%b unsup=%b",
                       want.rd_value, want.rd_write, want.rd_out, want.next_pc,
                       want.taken, want.unsupported);
              $display("  actual:   val=%h wr=%b rd=%0d npc=%h taken=%b unsup=%b",
                       got.rd_value, got.rd_write, got.rd_out, got.next_pc,
                       got.taken, got.unsupported);
            end
          end
        end
      end
    end
    error_count       <= errors;
    pending_count     <= expected_results.size();
    checked_count     <= checked;
    taken_count       <= redirects;
    unsupported_count <= rejects;
  end

endmodule

// File: dv/rv32i_integer_execute_core_tb.sv
// ----------------------------------------------------------------------------
// rv32i_integer_execute_core_tb
// Drives instruction words into the execute core: a directed set covering
// every class and unhandled encoding, with operand extremes, then a
// long random stream. Both channels idle at random in phases, and the result
// side holds off once for a long stretch to back the pipeline up. The checker
// beside the core predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module rv32i_integer_execute_core_tb;
  import rvex_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_RSVD6   = 3'd6;
  localparam logic [2:0] MODE_RSVD7   = 3'd7;
  localparam logic [2:0] F3_BR_RSVD2  = 3'd2;
  localparam logic [2:0] F3_BR_RSVD3  = 3'd3;
  localparam int         RANDOM_WORDS = 1400;
  localparam int         PHASE_LEN    = 175;
  localparam int         STALL_AT     = 300;
  localparam int         STALL_CYCLES = 80;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         IDLE_LIMIT   = 2000;

  logic        clk;
  logic        rst;
  int          sent_count;
  int          directed_count;
  int unsigned error_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned taken_count;
  int unsigned unsupported_count;

  rvex_in_if  instr_ch ();
  rvex_out_if result_ch ();

  rv32i_integer_execute_core dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  rv32i_integer_execute_core_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .instr             (instr_ch),
    .result            (result_ch),
    .error_count       (error_count),
    .pending_count     (pending_count),
    .checked_count     (checked_count),
    .taken_count       (taken_count),
    .unsupported_count (unsupported_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Rotate phases: both sides idle, neither, sender only, receiver only
  function automatic int pick_gap(input int idx, input bit sender_side);
    int  phase;
    bit  idles;
    phase = (idx / PHASE_LEN) % 4;
    idles = (phase == 0) || (sender_side ? (phase == 2) : (phase == 3));
    return idles ? int'($urandom_range(0, 10)) : 0;
  endfunction

  // Mix operand extremes, short shift counts, 12-bit values and raw randoms
  function automatic logic [31:0] rand_operand();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0: r = 32'h0000_0000;
      1: r = 32'hFFFF_FFFF;
      2: r = 32'h8000_0000;
      3: r = 32'h7FFF_FFFF;
      4: r = {27'b0, r[4:0]};
      5: r = {{20{r[11]}}, r[11:0]};
      default: ;
    endcase
    return r;
  endfunction

  // Offer one instruction word and hold it until accepted
  task automatic send_instr(
    input logic [2:0]  mode,
    input logic [2:0]  f3,
    input logic        alt,
    input logic [31:0] a,
    input logic [31:0] b,
    input logic [31:0] imm,
    input logic [31:0] pc,
    input logic [4:0]  rd
  );
    int gap;
    gap = pick_gap(sent_count, 1'b1);
    if (gap > 0) begin
      instr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_ch.valid     <= 1'b1;
    instr_ch.mode      <= mode;
    instr_ch.funct3    <= f3;
    instr_ch.alt_bit   <= alt;
    instr_ch.rs1_value <= a;
    instr_ch.rs2_value <= b;
    instr_ch.imm       <= imm;
    instr_ch.pc        <= pc;
    instr_ch.rd_index  <= rd;
    do @(posedge clk); while (!instr_ch.ready);
    sent_count++;
  endtask

  // Instruction stimulus and verdict
  initial begin
    logic [2:0]  mode;
    logic [31:0] a;
    sent_count         = 0;
    instr_ch.valid     <= 1'b0;
    instr_ch.mode      <= MODE_UPPER;
    instr_ch.funct3    <= F3_ADD;
    instr_ch.alt_bit   <= 1'b0;
    instr_ch.rs1_value <= '0;
    instr_ch.rs2_value <= '0;
    instr_ch.imm       <= '0;
    instr_ch.pc        <= '0;
    instr_ch.rd_index  <= '0;
    do @(posedge clk); while (rst);

    // upper-immediate, jumps with wrap and odd jalr targets
    send_instr(MODE_UPPER, F3_ADD, 1'b0, '0, '0, 32'h8000_0000, 32'h0000_1000, 5'd0);
    send_instr(MODE_UPPER, F3_AND, 1'b1, '1, '1, 32'h7FFF_FFFF, 32'hFFFF_FFFC, 5'd31);
    send_instr(MODE_JAL, F3_ADD, 1'b0, '0, '0, 32'h0000_0008, 32'hFFFF_FFFC, 5'd1);
    send_instr(MODE_JAL, F3_SR, 1'b0, '1, '0, 32'hFFFF_F000, 32'h0000_0400, 5'd5);
    send_instr(MODE_JALR, F3_ADD, 1'b0, 32'h0000_1001, '0, '0, 32'h0000_0200, 5'd2);
    send_instr(MODE_JALR, F3_XOR, 1'b1, 32'hFFFF_FFFF, '0, 32'h0000_0002, 32'hFFFF_FFFC,
               5'd3);
    // reg-imm ops with sign-extended 12-bit immediates and junk upper bits
    send_instr(MODE_OPIMM, F3_ADD, 1'b1, 32'h0000_0010, '0, 32'hABCD_E800, '0, 5'd4);
    send_instr(MODE_OPIMM, F3_SLT, 1'b0, 32'h8000_0000, '0, 32'h0000_0001, '0, 5'd6);
    send_instr(MODE_OPIMM, F3_SLTU, 1'b0, 32'h0000_0001, '0, 32'h0000_0FFF, '0, 5'd7);
    send_instr(MODE_OPIMM, F3_XOR, 1'b0, 32'h5555_5555, '0, 32'h0000_0FFF, '0, 5'd8);
    send_instr(MODE_OPIMM, F3_OR, 1'b0, 32'h1234_5678, '0, 32'h7FFF_F0F0, '0, 5'd9);
    send_instr(MODE_OPIMM, F3_AND, 1'b0, 32'hFFFF_FFFF, '0, 32'h0000_0800, '0, 5'd10);
    send_instr(MODE_OPIMM, F3_SLL, 1'b0, 32'h0000_0001, '0, 32'h0000_0004, '0, 5'd11);
    send_instr(MODE_OPIMM, F3_SR, 1'b1, 32'h8000_0000, '0, 32'h0000_0404, '0, 5'd12);
    // branches, including the equal case of both greater-or-equal compares
    send_instr(MODE_BRANCH, F3_BEQ, 1'b0, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'hFFFF_FFF0,
               32'h0000_0008, 5'd13);
    send_instr(MODE_BRANCH, F3_BLT, 1'b0, 32'h8000_0000, '0, 32'h0000_0100, 32'h100, 5'd14);
    send_instr(MODE_BRANCH, F3_BGE, 1'b0, 32'h8000_0001, 32'h8000_0001, 32'h0000_0040,
               32'h200, 5'd15);
    send_instr(MODE_BRANCH, F3_BLTU, 1'b0, '0, 32'hFFFF_FFFF, 32'h0000_0010, 32'h300, 5'd16);
    send_instr(MODE_BRANCH, F3_BGEU, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h0000_0020,
               32'hFFFF_FFF0, 5'd17);
    send_instr(MODE_BRANCH, F3_BR_RSVD2, 1'b0, '0, '0, 32'h0000_0010, 32'h400, 5'd18);
    send_instr(MODE_BRANCH, F3_BR_RSVD3, 1'b1, '1, '1, 32'h0000_0010, 32'h500, 5'd19);
    // reg-reg ops: carry-out add, borrow sub, top shift counts, signed compare
    send_instr(MODE_OP, F3_ADD, 1'b0, 32'hFFFF_FFFF, 32'h0000_0001, '0, '0, 5'd20);
    send_instr(MODE_OP, F3_ADD, 1'b1, 32'h0000_0000, 32'h0000_0001, '0, '0, 5'd21);
    send_instr(MODE_OP, F3_SLL, 1'b0, 32'h0000_0001, 32'hFFFF_FFFF, '0, '0, 5'd22);
    send_instr(MODE_OP, F3_SR, 1'b1, 32'h8000_0000, 32'h0000_001F, '0, '0, 5'd23);
    send_instr(MODE_OP, F3_SLT, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, 5'd24);
    send_instr(MODE_OP, F3_AND, 1'b1, 32'hF0F0_F0F0, 32'hFF00_FF00, '0, '0, 5'd25);
    // unassigned classes
    send_instr(MODE_RSVD6, F3_ADD, 1'b0, '1, '1, '1, 32'h0000_0600, 5'd26);
    send_instr(MODE_RSVD7, F3_AND, 1'b1, '1, '1, '1, 32'hFFFF_FFFC, 5'd27);
    directed_count = sent_count;

    // random stream over every class and encoding
    repeat (RANDOM_WORDS) begin
      if ($urandom_range(0, 15) == 0) mode = 3'($urandom_range(MODE_RSVD6, MODE_RSVD7));
      else                            mode = 3'($urandom_range(MODE_UPPER, MODE_OP));
      a = rand_operand();
      send_instr(mode, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), a,
                 ($urandom_range(0, 3) == 0) ? a : rand_operand(), rand_operand(),
                 $urandom(), 5'($urandom_range(0, 31)));
    end
    instr_ch.valid <= 1'b0;

    // drain: let the checker record the last word, then wait out the pipe
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d instruction words (%0d directed, rest random) across all classes",
             sent_count, directed_count);
    $display("checked %0d results: %0d redirects, %0d unsupported, %0d still expected",
             checked_count, taken_count, unsupported_count, pending_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("rv32i_integer_execute_core_tb: done, clean");
    end else begin
      $display("rv32i_integer_execute_core_tb: done, errors");
    end
    $finish;
  end

  // Result side: random hold-offs, plus one long stall to fill the pipe
  initial begin
    int delivered;
    int gap;
    delivered = 0;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = (delivered == STALL_AT) ? STALL_CYCLES : pick_gap(delivered, 1'b0);
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      delivered++;
    end
  end

  // Abort when no word moves on either channel for too long
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (rst || (instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", idle);
        $display("rv32i_integer_execute_core_tb: done, errors");
        $finish;
      end
    end
  end

endmodule

// File: files.f
rtl/rvex_pkg.sv
rtl/rvex_if.sv
rtl/rvex_decode.sv
rtl/rvex_alu.sv
rtl/rvex_resolve.sv
rtl/rv32i_integer_execute_core.sv
rtl/rvex_checker.sv
dv/rv32i_integer_execute_core_checker.sv
dv/rv32i_integer_execute_core_tb.sv
